@@ design/fragment_reassembly_tracker_unit_macros.svh @@
// Assertion macros for the fragment reassembly tracker.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/frt_pkg.sv @@
package frt_pkg;
   localparam int DEFAULT_TABLE_ENTRIES = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [23:0] BYTES_MAX = 24'hFFFFFF;
   localparam logic [15:0] BROADCAST = 16'hFFFF;

   typedef enum logic [1:0] {
      EV_ACCEPT = 2'd0, EV_DROP_DEST = 2'd1, EV_DROP_MISS = 2'd2, EV_DROP_FULL = 2'd3
   } event_type;

   localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
   localparam logic [1:0] REG_PROMISCUOUS = 2'd1;
   localparam logic [1:0] REG_CHECK_INTERVAL = 2'd2;
   localparam logic [1:0] REG_TIMEOUT = 2'd3;
   localparam int CSR_INDEX_WIDTH = 8;

   typedef struct packed {
      logic        action;
      logic [31:0] now_ms;
      logic [15:0] source_node;
      logic [15:0] dest_node;
      logic [7:0]  msg_priority;
      logic        is_fragment;
      logic [31:0] fragment_sequence;
      logic [7:0]  fragment_index;
      logic        more_fragments;
      logic [15:0] byte_count;
      logic        is_data;
   } req_type;

   typedef struct packed {
      event_type   out_event;
      logic [15:0] out_source;
      logic [15:0] out_dest;
      logic [7:0]  out_priority;
      logic [23:0] out_bytes;
      logic        forward_upstream;
      logic        last_result;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;     // capture the request
      logic match_start;  // register match and free-slot results
      logic decide;       // apply the message decision
      logic sweep_start;  // record the sweep time when the sweep runs
      logic sweep_step;   // examine one entry
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_sweep;
      logic sweep_run;    // interval elapsed
      logic msg_emits;    // decision gives a result
      logic step_emits;   // current scan entry gives a result
      logic step_last;    // current scan entry is the last one
      logic any_left;     // a later entry will also give a result
   } stat_type;

   function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [15:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {9'd0, b};
      return s[24] ? BYTES_MAX : s[23:0];
   endfunction
endpackage

@@ design/frt_channel_if.sv @@
interface frt_channel_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ design/frt_csr_if.sv @@
interface frt_csr_if import frt_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [31:0]                data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/frt_datapath.sv @@
module frt_datapath import frt_pkg::*; #(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_in,
   input  ctrl_type    ctrl,
   input  logic [15:0] own_address,
   input  logic        promiscuous,
   input  logic [31:0] check_interval_ms,
   input  logic [31:0] reassembly_timeout_ms,
   output stat_type    stat,
   output rsp_type     msg_rsp,
   output rsp_type     step_rsp
);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   req_type     req_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [15:0] src_ff [TABLE_ENTRIES];
   logic [7:0]  pri_ff [TABLE_ENTRIES];
   logic [31:0] seq_ff [TABLE_ENTRIES];
   logic [8:0]  nxt_ff [TABLE_ENTRIES];
   logic [23:0] byt_ff [TABLE_ENTRIES];
   logic [31:0] tim_ff [TABLE_ENTRIES];
   logic [15:0] dst_ff [TABLE_ENTRIES];
   logic [31:0] last_sweep_ff;

   logic          hit_ff, free_ok_ff, run_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, scan_ff;
   logic [TABLE_ENTRIES-1:0] expired_ff;
   logic [4:0]    emitted_ff;

   logic [TABLE_ENTRIES-1:0] match_vec;
   logic          hit_in, free_ok_in;
   logic [IW-1:0] hit_idx_in, free_idx_in;

   always_comb begin
      hit_in = 1'b0; hit_idx_in = '0; free_ok_in = 1'b0; free_idx_in = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && src_ff[i] == req_ff.source_node &&
                        pri_ff[i] == req_ff.msg_priority &&
                        seq_ff[i] == req_ff.fragment_sequence;
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin hit_in = 1'b1; hit_idx_in = IW'(i); end
         if (!valid_ff[i]) begin free_ok_in = 1'b1; free_idx_in = IW'(i); end
      end
   end

   // Decision on the registered match.
   logic        dest_ok, msg_emit;
   logic [8:0]  hnext;
   logic [23:0] hsum;
   always_comb begin
      dest_ok = promiscuous || req_ff.dest_node == own_address ||
                req_ff.dest_node == BROADCAST;
      hnext = nxt_ff[hit_idx_ff];
      hsum = sat_add(byt_ff[hit_idx_ff], req_ff.byte_count);
      msg_rsp = '0;
      msg_rsp.out_source = req_ff.source_node;
      msg_rsp.out_dest = req_ff.dest_node;
      msg_rsp.out_priority = req_ff.msg_priority;
      msg_rsp.out_bytes = {8'd0, req_ff.byte_count};
      msg_rsp.last_result = 1'b1;
      msg_emit = 1'b1;
      if (!dest_ok) begin
         msg_rsp.out_event = EV_DROP_DEST;
      end else if (!req_ff.is_fragment) begin
         msg_rsp.out_event = EV_ACCEPT;
         msg_rsp.forward_upstream = req_ff.is_data;
      end else if (hit_ff) begin
         if ({1'b0, req_ff.fragment_index} < hnext) begin
            msg_emit = 1'b0;
         end else if ({1'b0, req_ff.fragment_index} == hnext) begin
            msg_emit = !req_ff.more_fragments;
            msg_rsp.out_event = EV_ACCEPT;
            msg_rsp.out_bytes = hsum;
            msg_rsp.forward_upstream = req_ff.is_data;
         end else begin
            msg_rsp.out_event = EV_DROP_MISS;
            msg_rsp.out_bytes = hsum;
         end
      end else if (req_ff.fragment_index != 8'd0) begin
         msg_rsp.out_event = EV_DROP_MISS;
      end else if (!req_ff.more_fragments) begin
         msg_rsp.out_event = EV_ACCEPT;
         msg_rsp.forward_upstream = req_ff.is_data;
      end else if (!free_ok_ff) begin
         msg_rsp.out_event = EV_DROP_FULL;
      end else begin
         msg_emit = 1'b0;
      end
   end

   // Sweep step: one entry per cycle while the output register is not stalled.
   logic step_emit, later;
   always_comb begin
      step_emit = run_ff && expired_ff[scan_ff] && emitted_ff < 5'(MAX_RESULTS);
      later = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (IW'(i) > scan_ff && expired_ff[i]) later = 1'b1;
      end
      later = later && (emitted_ff + 5'(step_emit)) < 5'(MAX_RESULTS);
      step_rsp.out_event = EV_DROP_MISS;
      step_rsp.out_source = src_ff[scan_ff];
      step_rsp.out_dest = dst_ff[scan_ff];
      step_rsp.out_priority = pri_ff[scan_ff];
      step_rsp.out_bytes = byt_ff[scan_ff];
      step_rsp.forward_upstream = 1'b0;
      step_rsp.last_result = !later;
   end

   assign stat.is_sweep = req_ff.action;
   assign stat.sweep_run = run_ff;
   assign stat.msg_emits = msg_emit;
   assign stat.step_emits = step_emit;
   assign stat.step_last = (32'(scan_ff) == 32'(TABLE_ENTRIES - 1));
   assign stat.any_left = later;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_sweep_ff <= '0;
         run_ff <= 1'b0;
      end else begin
         if (ctrl.load_req) req_ff <= req_in;
         if (ctrl.match_start) begin
            hit_ff <= hit_in; hit_idx_ff <= hit_idx_in;
            free_ok_ff <= free_ok_in; free_idx_ff <= free_idx_in;
            scan_ff <= '0; emitted_ff <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               expired_ff[i] <= valid_ff[i] &&
                  (req_ff.now_ms - tim_ff[i]) >= reassembly_timeout_ms;
            end
            run_ff <= (req_ff.now_ms - last_sweep_ff) >= check_interval_ms;
         end
         if (ctrl.sweep_start && run_ff) last_sweep_ff <= req_ff.now_ms;
         if (ctrl.sweep_step) begin
            if (step_emit) begin
               valid_ff[scan_ff] <= 1'b0;
               emitted_ff <= emitted_ff + 5'd1;
            end
            scan_ff <= scan_ff + IW'(1);
         end
         if (ctrl.decide && dest_ok && req_ff.is_fragment) begin
            if (hit_ff) begin
               if ({1'b0, req_ff.fragment_index} == hnext) begin
                  byt_ff[hit_idx_ff] <= hsum;
                  tim_ff[hit_idx_ff] <= req_ff.now_ms;
                  nxt_ff[hit_idx_ff] <= hnext + 9'd1;
                  if (!req_ff.more_fragments) valid_ff[hit_idx_ff] <= 1'b0;
               end else if ({1'b0, req_ff.fragment_index} > hnext) begin
                  valid_ff[hit_idx_ff] <= 1'b0;
               end
            end else if (req_ff.fragment_index == 8'd0 && req_ff.more_fragments &&
                         free_ok_ff) begin
               valid_ff[free_idx_ff] <= 1'b1;
               src_ff[free_idx_ff] <= req_ff.source_node;
               pri_ff[free_idx_ff] <= req_ff.msg_priority;
               seq_ff[free_idx_ff] <= req_ff.fragment_sequence;
               nxt_ff[free_idx_ff] <= 9'd1;
               byt_ff[free_idx_ff] <= {8'd0, req_ff.byte_count};
               tim_ff[free_idx_ff] <= req_ff.now_ms;
               dst_ff[free_idx_ff] <= req_ff.dest_node;
            end
         end
      end
   end
endmodule

@@ design/frt_controller.sv @@
module frt_controller import frt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     out_busy,
   output logic     out_load,
   output logic     out_from_step,
   input  stat_type stat,
   output ctrl_type ctrl
);
   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_DECIDE, S_SWEEP} state_type;
   state_type state_ff;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      ctrl = '0;
      out_load = 1'b0;
      out_from_step = 1'b0;
      ctrl.load_req = (state_ff == S_IDLE) && req_valid;
      ctrl.match_start = (state_ff == S_MATCH);
      if (state_ff == S_DECIDE && !out_busy) begin
         if (stat.is_sweep) ctrl.sweep_start = 1'b1;
         else begin
            ctrl.decide = 1'b1;
            out_load = stat.msg_emits;
         end
      end
      if (state_ff == S_SWEEP && !out_busy) begin
         ctrl.sweep_step = 1'b1;
         out_load = stat.step_emits;
         out_from_step = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE:   if (req_valid) state_ff <= S_MATCH;
            S_MATCH:  state_ff <= S_DECIDE;
            S_DECIDE: if (ctrl.sweep_start) state_ff <= stat.sweep_run ? S_SWEEP : S_IDLE;
                      else if (ctrl.decide) state_ff <= S_IDLE;
            S_SWEEP:  if (ctrl.sweep_step && (stat.step_last || !stat.any_left))
                         state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ design/fragment_reassembly_tracker_unit.sv @@
// Fragment reassembly tracker top level.
// A message's request is registered, then its match and free-slot results; the decision then
// loads any result into the output register once it is free. A new message is taken only when the controller
// is idle again; a sweep that runs scans entries one at a time, through the last it reports.
// Reset is synchronous and active high; it clears valid bits and the sweep time and loads the configuration defaults.
`include "fragment_reassembly_tracker_unit_macros.svh"
module fragment_reassembly_tracker_unit import frt_pkg::*; #(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input logic clock,
   input logic reset,
   frt_channel_if.sink   req,
   frt_channel_if.source rsp,
   frt_csr_if.sink       csr
);
   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   logic [15:0] own_address_ff;
   logic        promiscuous_ff;
   logic [31:0] check_interval_ff;
   logic [31:0] timeout_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         promiscuous_ff <= 1'b0;
         check_interval_ff <= 32'd2000;
         timeout_ff <= 32'd5000;
      end else if (csr.valid) begin
         if (csr.index == CSR_INDEX_WIDTH'(REG_OWN_ADDRESS)) own_address_ff <= csr.data[15:0];
         if (csr.index == CSR_INDEX_WIDTH'(REG_PROMISCUOUS)) promiscuous_ff <= csr.data[0];
         if (csr.index == CSR_INDEX_WIDTH'(REG_CHECK_INTERVAL)) check_interval_ff <= csr.data;
         if (csr.index == CSR_INDEX_WIDTH'(REG_TIMEOUT)) timeout_ff <= csr.data;
      end
   end

   ctrl_type ctrl;
   stat_type stat;
   rsp_type  msg_rsp, step_rsp;
   logic     out_load, out_from_step;

   // The output register holds one result; the controller stalls while it is full
   // and not being taken in this cycle.
   logic    out_valid_ff;
   rsp_type out_ff;
   logic    out_busy;
   assign out_busy = out_valid_ff && !rsp.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
      if (out_load) out_ff <= out_from_step ? step_rsp : msg_rsp;
   end

   frt_controller u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .out_busy, .out_load, .out_from_step,
      .stat, .ctrl
   );

   frt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock, .reset,
      .req_in(req.payload), .ctrl,
      .own_address(own_address_ff), .promiscuous(promiscuous_ff),
      .check_interval_ms(check_interval_ff), .reassembly_timeout_ms(timeout_ff),
      .stat, .msg_rsp, .step_rsp
   );

   // A result is never loaded while the output register is stalled.
   `FRT_ASSERT_IMPL(a_no_overwrite, clock, reset, out_load, !out_busy, "result overwritten")
   // A stalled result holds its payload.
   `FRT_ASSERT_NEXT(a_hold, clock, reset, out_busy, $stable(out_ff), "stalled result changed")
   // A request is never taken in a cycle in which a result is loaded.
   `FRT_ASSERT_IMPL(a_one_item, clock, reset, req.valid && req.ready, !out_load, "take in load")
endmodule

@@ sim/fragment_reassembly_tracker_unit_test.sv @@
`timescale 1ns / 100ps
module fragment_reassembly_tracker_unit_test;
   import frt_pkg::*;

   // The block under test filters messages by destination, tracks fragmented
   // packets in a small table and abandons stale assemblies on sweep
   // requests. A local tracker mirrors the table and the registers, predicts the
   // results of each accepted transfer and queues them for comparison.

   localparam int ENTRIES = DEFAULT_TABLE_ENTRIES;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 144;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frt_channel_if #(.payload_type(req_type)) req ();
   frt_channel_if #(.payload_type(rsp_type)) rsp ();
   frt_csr_if csr ();

   fragment_reassembly_tracker_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the registers and the reassembly table.
   logic [15:0] own_addr;
   logic        promisc;
   logic [31:0] sweep_interval;
   logic [31:0] abandon_after;
   logic        slot_busy [ENTRIES];
   logic [15:0] slot_src [ENTRIES];
   logic [7:0]  slot_pri [ENTRIES];
   logic [31:0] slot_seq [ENTRIES];
   logic [8:0]  slot_next [ENTRIES];
   logic [23:0] slot_bytes [ENTRIES];
   logic [31:0] slot_stamp [ENTRIES];
   logic [15:0] slot_dst [ENTRIES];
   logic [31:0] last_sweep;

   rsp_type pending_reports[$];
   int failures = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   function automatic rsp_type make_report(event_type ev, logic [15:0] s, logic [15:0] d,
                                           logic [7:0] p, logic [23:0] b, logic f);
      rsp_type r;
      r.out_event = ev;
      r.out_source = s;
      r.out_dest = d;
      r.out_priority = p;
      r.out_bytes = b;
      r.forward_upstream = f;
      r.last_result = 1'b0;
      return r;
   endfunction

   function automatic logic [23:0] add_bytes(logic [23:0] a, logic [15:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {9'd0, b};
      return s[24] ? 24'hFFFFFF : s[23:0];
   endfunction

   // Work out the results of one accepted message and append them to the queue.
   task automatic track_message(input req_type m);
      rsp_type found[$];
      int hit;
      int slot;
      hit = -1;
      slot = -1;
      if (m.action) begin
         if (m.now_ms - last_sweep >= sweep_interval) begin
            last_sweep = m.now_ms;
            for (int i = 0; i < ENTRIES; i++)
               if (slot_busy[i] && found.size() < MAX_RESULTS &&
                   m.now_ms - slot_stamp[i] >= abandon_after) begin
                  found.insert(found.size(), make_report(EV_DROP_MISS, slot_src[i],
                               slot_dst[i], slot_pri[i], slot_bytes[i], 1'b0));
                  slot_busy[i] = 1'b0;
               end
         end
      end else if (!(promisc || m.dest_node == own_addr || m.dest_node == BROADCAST)) begin
         found.insert(found.size(), make_report(EV_DROP_DEST, m.source_node, m.dest_node,
                      m.msg_priority, {8'd0, m.byte_count}, 1'b0));
      end else if (!m.is_fragment) begin
         found.insert(found.size(), make_report(EV_ACCEPT, m.source_node, m.dest_node,
                      m.msg_priority, {8'd0, m.byte_count}, m.is_data));
      end else begin
         for (int i = ENTRIES - 1; i >= 0; i--)
            if (slot_busy[i] && slot_src[i] == m.source_node &&
                slot_pri[i] == m.msg_priority && slot_seq[i] == m.fragment_sequence)
               hit = i;
         if (hit >= 0) begin
            if ({1'b0, m.fragment_index} == slot_next[hit]) begin
               slot_bytes[hit] = add_bytes(slot_bytes[hit], m.byte_count);
               slot_stamp[hit] = m.now_ms;
               slot_next[hit] = slot_next[hit] + 9'd1;
               if (!m.more_fragments) begin
                  found.insert(found.size(), make_report(EV_ACCEPT, m.source_node,
                               m.dest_node, m.msg_priority, slot_bytes[hit], m.is_data));
                  slot_busy[hit] = 1'b0;
               end
            end else if ({1'b0, m.fragment_index} > slot_next[hit]) begin
               found.insert(found.size(), make_report(EV_DROP_MISS, m.source_node,
                            m.dest_node, m.msg_priority,
                            add_bytes(slot_bytes[hit], m.byte_count), 1'b0));
               slot_busy[hit] = 1'b0;
            end
         end else if (m.fragment_index != 0) begin
            found.insert(found.size(), make_report(EV_DROP_MISS, m.source_node, m.dest_node,
                         m.msg_priority, {8'd0, m.byte_count}, 1'b0));
         end else if (!m.more_fragments) begin
            found.insert(found.size(), make_report(EV_ACCEPT, m.source_node, m.dest_node,
                         m.msg_priority, {8'd0, m.byte_count}, m.is_data));
         end else begin
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!slot_busy[i]) slot = i;
            if (slot < 0) begin
               found.insert(found.size(), make_report(EV_DROP_FULL, m.source_node,
                            m.dest_node, m.msg_priority, {8'd0, m.byte_count}, 1'b0));
            end else begin
               slot_busy[slot] = 1'b1;
               slot_src[slot] = m.source_node;
               slot_pri[slot] = m.msg_priority;
               slot_seq[slot] = m.fragment_sequence;
               slot_next[slot] = 9'd1;
               slot_bytes[slot] = {8'd0, m.byte_count};
               slot_stamp[slot] = m.now_ms;
               slot_dst[slot] = m.dest_node;
            end
         end
      end
      if (found.size() > 0) found[found.size() - 1].last_result = 1'b1;
      foreach (found[k]) pending_reports.insert(pending_reports.size(), found[k]);
   endtask

   // Inputs change only at the rising edge, so outputs sampled there are stable.
   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
   end

   // Result side: random stall bursts, compare every accepted transfer.
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 8);
            rsp.ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp.payload);
            failures++;
         end else begin
            rsp_type want;
            want = pending_reports.pop_front();
            if (rsp.payload !== want) begin
               $display("%0t: result mismatch, expected %p, actual %p", $time, want, rsp.payload);
               failures++;
            end
         end
      end
   end

   // Watchdog: a long stretch without any transfer ends the run.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One register write; the write strobe drops for a cycle before the next one.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= CSR_INDEX_WIDTH'(index);
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (index)
         REG_OWN_ADDRESS:    own_addr = value[15:0];
         REG_PROMISCUOUS:    promisc = value[0];
         REG_CHECK_INTERVAL: sweep_interval = value;
         REG_TIMEOUT:        abandon_after = value;
         default:            ;
      endcase
      @(posedge clock);
   endtask

   // Send one message; the valid stays high across back-to-back transfers.
   task automatic send_message(input req_type m);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= m;
      do @(posedge clock); while (!req.ready);
      track_message(m);
   endtask

   // Wait until the block has drained, with margin for a sweep in flight.
   task automatic drain;
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3 * ENTRIES + 10) @(posedge clock);
   endtask

   function automatic req_type frag(logic [31:0] t, logic [15:0] s, logic [15:0] d,
                                    logic [7:0] p, logic [31:0] q, logic [7:0] ix,
                                    logic mf, logic [15:0] n, logic dat);
      req_type m;
      m.action = 1'b0;
      m.now_ms = t;
      m.source_node = s;
      m.dest_node = d;
      m.msg_priority = p;
      m.is_fragment = 1'b1;
      m.fragment_sequence = q;
      m.fragment_index = ix;
      m.more_fragments = mf;
      m.byte_count = n;
      m.is_data = dat;
      return m;
   endfunction

   // A message with every field random.
   function automatic req_type noise_message();
      logic [159:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return req_type'(noise[$bits(req_type)-1:0]);
   endfunction

   function automatic req_type sweep_at(logic [31:0] t);
      req_type m;
      m = noise_message();
      m.action = 1'b1;
      m.now_ms = t;
      return m;
   endfunction

   // Directed rows: the message, and an expected result where it is plain to see
   // (has_check set), otherwise left to the tracker alone.
   typedef struct {
      req_type msg;
      bit      has_check;
      rsp_type want;
   } directed_row_type;

   directed_row_type plan[$];

   task automatic add_row(input req_type m, input bit chk, input rsp_type w);
      directed_row_type r;
      r.msg = m;
      r.has_check = chk;
      r.want = w;
      plan.insert(plan.size(), r);
   endtask

   initial begin
      req_type m;
      rsp_type none;
      rsp_type w;
      logic [31:0] clock_ms;
      int streams;
      bit held;
      none = '0;
      held = 1'b0;

      own_addr = 16'd0;
      promisc = 1'b0;
      sweep_interval = 32'd2000;
      abandon_after = 32'd5000;
      last_sweep = 32'd0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_busy[i] = 1'b0;
         slot_src[i] = '0; slot_pri[i] = '0; slot_seq[i] = '0; slot_next[i] = '0;
         slot_bytes[i] = '0; slot_stamp[i] = '0; slot_dst[i] = '0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with reset register values first.
      m = frag(32'd10, 16'h1234, 16'h5555, 8'd7, 32'd1, 8'd0, 1'b0, 16'd100, 1'b1);
      m.is_fragment = 1'b0;
      w = make_report(EV_DROP_DEST, 16'h1234, 16'h5555, 8'd7, 24'd100, 1'b0);
      w.last_result = 1'b1;
      add_row(m, 1, w);
      m.dest_node = 16'h0000;
      m.byte_count = 16'hFFFF;
      w = make_report(EV_ACCEPT, 16'h1234, 16'h0000, 8'd7, 24'hFFFF, 1'b1);
      w.last_result = 1'b1;
      add_row(m, 1, w);
      m.dest_node = BROADCAST;
      m.is_data = 1'b0;
      m.source_node = 16'hFFFF;
      m.msg_priority = 8'hFF;
      w = make_report(EV_ACCEPT, 16'hFFFF, 16'hFFFF, 8'hFF, 24'hFFFF, 1'b0);
      w.last_result = 1'b1;
      add_row(m, 1, w);
      // Fragment chain with a duplicate, then completion.
      add_row(frag(20, 1, 0, 3, 32'hFFFFFFFF, 0, 1, 16'hFFFF, 1), 0, none);
      add_row(frag(21, 1, 0, 3, 32'hFFFFFFFF, 1, 1, 16'hFFFF, 1), 0, none);
      add_row(frag(22, 1, 0, 3, 32'hFFFFFFFF, 0, 1, 16'd5, 1), 0, none);
      add_row(frag(23, 1, BROADCAST, 3, 32'hFFFFFFFF, 2, 0, 16'd1, 1), 0, none);
      // Gap in a chain.
      add_row(frag(30, 2, 0, 4, 9, 0, 1, 16'd50, 0), 0, none);
      add_row(frag(31, 2, 0, 4, 9, 3, 1, 16'd60, 0), 0, none);
      // First fragment with nonzero index, and a lone single fragment.
      w = make_report(EV_DROP_MISS, 16'd3, 16'd0, 8'd0, 24'd77, 1'b0);
      w.last_result = 1'b1;
      add_row(frag(40, 3, 0, 0, 5, 8'hFF, 1, 16'd77, 1), 1, w);
      add_row(frag(41, 3, 0, 0, 6, 0, 0, 16'd12, 1), 0, none);
      // Fill the table, overflow it, then abandon everything in one sweep.
      for (int i = 0; i < ENTRIES; i++)
         add_row(frag(100, 16'(i), 0, 1, 32'd1000 + i, 0, 1, 16'd9, 1), 0, none);
      w = make_report(EV_DROP_FULL, 16'hAAAA, 16'd0, 8'd1, 24'd9, 1'b0);
      w.last_result = 1'b1;
      add_row(frag(101, 16'hAAAA, 0, 1, 32'd7, 0, 1, 16'd9, 1), 1, w);
      add_row(sweep_at(32'd1000), 0, none);
      add_row(sweep_at(32'd9000), 0, none);

      foreach (plan[k]) begin
         if (plan[k].has_check) begin
            track_message(plan[k].msg);
            w = pending_reports[pending_reports.size() - 1];
            if (w !== plan[k].want) begin
               $display("%0t: row %0d prediction, expected %p, actual %p",
                        $time, k, plan[k].want, w);
               failures++;
            end
            void'(pending_reports.pop_back());
            pending_reports.insert(pending_reports.size(), plan[k].want);
            req.valid <= 1'b1;
            req.payload <= plan[k].msg;
            do @(posedge clock); while (!req.ready);
         end else begin
            send_message(plan[k].msg);
         end
      end
      drain();

      // Random phases, each under a different register setting.
      clock_ms = 32'd20000;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_register(REG_OWN_ADDRESS, 32'h0000FFFF);
               write_register(REG_PROMISCUOUS, 32'd0);
               write_register(REG_CHECK_INTERVAL, 32'd0);
               write_register(REG_TIMEOUT, 32'd0);
            end
            1: begin
               write_register(REG_OWN_ADDRESS, 32'h0000A5A5);
               write_register(REG_PROMISCUOUS, 32'd1);
               write_register(REG_CHECK_INTERVAL, 32'd50);
               write_register(REG_TIMEOUT, 32'd200);
            end
            2: begin
               write_register(REG_OWN_ADDRESS, 32'h00005A5A);
               write_register(REG_PROMISCUOUS, 32'd0);
               write_register(REG_CHECK_INTERVAL, 32'hFFFFFFFF);
               write_register(REG_TIMEOUT, 32'hFFFFFFFF);
            end
            default: begin
               write_register(REG_PROMISCUOUS, 32'd0);
               write_register(REG_CHECK_INTERVAL, 32'd10);
               write_register(REG_TIMEOUT, 32'd300);
               quiet = 1'b1;
            end
         endcase
         streams = 0;
         while (streams < RANDOM_ITEMS / 4) begin
            int kind;
            kind = $urandom_range(0, 9);
            clock_ms += $urandom_range(0, 60);
            if (kind < 6) begin
               // A well-formed chain, sometimes damaged by a gap or duplicate.
               logic [15:0] s;
               logic [7:0]  p;
               logic [31:0] q;
               logic [15:0] d;
               int len;
               s = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
               p = 8'($urandom);
               q = $urandom;
               d = $urandom_range(0, 2) == 0 ? BROADCAST : own_addr;
               len = $urandom_range(1, 5);
               for (int ix = 0; ix < len; ix++) begin
                  int jx;
                  jx = ix;
                  if ($urandom_range(0, 9) == 0) jx = ix + $urandom_range(1, 2);
                  if (ix > 0 && $urandom_range(0, 9) == 0) jx = ix - 1;
                  clock_ms += $urandom_range(0, 40);
                  send_message(frag(clock_ms, s, d, p, q, 8'(jx), ix != len - 1,
                                    16'($urandom), 1'($urandom)));
                  streams++;
               end
            end else if (kind < 8) begin
               m = noise_message();
               m.action = 1'b0;
               m.now_ms = clock_ms;
               if ($urandom_range(0, 1)) m.dest_node = own_addr;
               send_message(m);
               streams++;
            end else begin
               send_message(sweep_at($urandom_range(0, 3) == 0 ? $urandom :
                                     clock_ms + $urandom_range(0, 400)));
               streams++;
            end
            // Hold off the sender once until the block has caught up.
            if (phase == 1 && !held && streams >= 20) begin
               held = 1'b1;
               req.valid <= 1'b0;
               @(posedge clock);
               while (pending_reports.size() != 0) @(posedge clock);
            end
         end
         send_message(sweep_at(clock_ms + 32'h80000000));
         drain();
      end

      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
